@@ design/fsc_pkg.sv @@
// ----------------------------------------------------------------------------
// fsc_pkg: shared definitions of the FIRE step controller
// Field widths, register indexes and register reset values.
// ----------------------------------------------------------------------------
package fsc_pkg;

	localparam int POWER_W    = 48;
	localparam int NORM_W     = 48;
	localparam int KEEP_W     = 17;
	localparam int COEFF_W    = 32;
	localparam int DT_W       = 32;
	localparam int MIX_W      = 16;
	localparam int STEPS_W    = 8;
	localparam int CUT_W      = STEPS_W + 1;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_STEPS     = 3'd0,
		REG_GROW_FACTOR   = 3'd1,
		REG_SHRINK_FACTOR = 3'd2,
		REG_MIX_START     = 3'd3,
		REG_MIX_DECAY     = 3'd4,
		REG_DT_CEILING    = 3'd5,
		REG_DT_INITIAL    = 3'd6
	} cfg_reg_t;

	localparam logic [STEPS_W-1:0] MIN_STEPS_RST     = 8'd10;
	localparam logic [MIX_W-1:0]   GROW_FACTOR_RST   = 16'd19661;
	localparam logic [MIX_W-1:0]   SHRINK_FACTOR_RST = 16'd32768;
	localparam logic [MIX_W-1:0]   MIX_START_RST     = 16'd6554;
	localparam logic [MIX_W-1:0]   MIX_DECAY_RST     = 16'd64880;
	localparam logic [DT_W-1:0]    DT_CEILING_RST    = 32'd838861;
	localparam logic [DT_W-1:0]    DT_INITIAL_RST    = 32'd83886;

	// One in Q1.16, as carried by the keep coefficient.
	localparam logic [KEEP_W-1:0]  KEEP_ONE          = 17'd65536;

endpackage

@@ design/fsc_if.sv @@
// ----------------------------------------------------------------------------
// fsc_if: request and response channels of the FIRE step controller
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface fsc_req_if;
	import fsc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic signed [POWER_W-1:0] power;
	logic [NORM_W-1:0]         vel_norm_sq;
	logic [NORM_W-1:0]         force_norm_sq;

	modport source (output valid, kind, power, vel_norm_sq, force_norm_sq, input ready);
	modport sink   (input valid, kind, power, vel_norm_sq, force_norm_sq, output ready);
endinterface

interface fsc_rsp_if;
	import fsc_pkg::*;

	logic               valid;
	logic               ready;
	logic [KEEP_W-1:0]  keep_coeff;
	logic [COEFF_W-1:0] force_coeff;
	logic               zero_velocity;
	logic [DT_W-1:0]    new_dt;
	logic               dt_changed;

	modport source (output valid, keep_coeff, force_coeff, zero_velocity, new_dt, dt_changed,
			input ready);
	modport sink   (input valid, keep_coeff, force_coeff, zero_velocity, new_dt, dt_changed,
			output ready);
endinterface

@@ design/fire_step_controller_core.sv @@
// ----------------------------------------------------------------------------
// fire_step_controller_core: FIRE relaxation step controller
// Keeps time step, mixing factor and cut counter; computes the per-step
// mixing coefficients with bit-serial multiply, divide and square root.
// ----------------------------------------------------------------------------
// A normal request runs shift-add multiplication of mix^2 by |v|^2,
// restoring division by |F|^2 and digit-by-digit square root, one bit
// per cycle, and then hands the result to the output register once that
// register is free. A saturated force coefficient ends after the
// multiplication; a restart request or a zero force norm goes straight to
// the hand-off. The time step and mixing factor are updated in the cycle of
// acceptance, so the next request may follow as soon as the serial loops
// are free, even while the previous response still waits in the output
// register.
// Configuration writes take effect at the next request that uses them.
module fire_step_controller_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	fsc_req_if.sink                         req,
	fsc_rsp_if.source                       rsp
);
	import fsc_pkg::*;

	localparam int CNT_W    = 6;
	localparam int PROD_W   = 2 * MIX_W + NORM_W;
	localparam int QUO_W    = 64;
	localparam int ROOT_W   = QUO_W / 2;
	localparam int SREM_W   = ROOT_W + 2;
	localparam int GROW_SH  = 14;
	localparam int GROWN_W  = DT_W + MIX_W - GROW_SH;

	typedef enum logic [2:0] {ST_IDLE, ST_MUL, ST_DIV, ST_SQRT, ST_DONE} state_t;

	state_t state_q;
	logic [CNT_W-1:0] cnt_q;

	// Configuration registers.
	logic [STEPS_W-1:0] min_steps_q;
	logic [MIX_W-1:0]   grow_factor_q;
	logic [MIX_W-1:0]   shrink_factor_q;
	logic [MIX_W-1:0]   mix_start_q;
	logic [MIX_W-1:0]   mix_decay_q;
	logic [DT_W-1:0]    dt_ceiling_q;
	logic [DT_W-1:0]    dt_initial_q;

	// Controller state.
	logic [DT_W-1:0]         step_q;
	logic [MIX_W-1:0]        mix_q;
	logic signed [CUT_W-1:0] cut_q;

	// Serial datapath.
	logic [2*MIX_W-1:0]  m2_q;
	logic [NORM_W-1:0]   v_q;
	logic [NORM_W-1:0]   f_q;
	logic [PROD_W-1:0]   acc_q;
	logic [NORM_W-1:0]   rem_q;
	logic [SREM_W-1:0]   srem_q;
	logic [ROOT_W-1:0]   root_q;
	logic [COEFF_W-1:0]  fc_q;
	logic [KEEP_W-1:0]   keep_w_q;
	logic                zv_w_q;
	logic [DT_W-1:0]     dt_w_q;
	logic                chg_w_q;

	// Output register.
	logic                rsp_valid_q;
	logic [KEEP_W-1:0]   keep_q;
	logic [COEFF_W-1:0]  force_q;
	logic                zv_q;
	logic [DT_W-1:0]     new_dt_q;
	logic                chg_q;

	logic accept;
	logic is_restart;
	logic negative;
	logic zero_force;
	logic out_free;
	logic out_load;

	logic [DT_W+MIX_W-1:0] shrink_prod;
	logic [DT_W+MIX_W-1:0] grow_prod;
	logic [GROWN_W-1:0]    grown;
	logic [DT_W-1:0]       grown_cap;
	logic [2*MIX_W-1:0]    decay_prod;

	logic [DT_W-1:0]         step_d;
	logic [MIX_W-1:0]        mix_d;
	logic signed [CUT_W-1:0] cut_d;

	logic [2*MIX_W:0]  mul_sum;
	logic [PROD_W-1:0] acc_mul;
	logic              saturate;
	logic [NORM_W:0]   div_t;
	logic              div_ge;
	logic [SREM_W+1:0] sq_t;
	logic [SREM_W+1:0] sq_trial;
	logic              sq_ge;

	assign accept     = req.valid && req.ready;
	assign req.ready  = (state_q == ST_IDLE);
	assign is_restart = !req.kind;
	assign negative   = req.power[POWER_W-1];
	assign zero_force = (req.force_norm_sq == '0);
	assign out_free   = !rsp_valid_q || rsp.ready;
	assign out_load   = (state_q == ST_DONE) && out_free;

	// Next controller state for an accepted request.
	assign shrink_prod = step_q * shrink_factor_q;
	assign grow_prod   = step_q * grow_factor_q;
	assign grown       = grow_prod[DT_W+MIX_W-1:GROW_SH];
	assign grown_cap   = (grown > GROWN_W'(dt_ceiling_q)) ? dt_ceiling_q : grown[DT_W-1:0];
	assign decay_prod  = mix_q * mix_decay_q;

	always_comb begin
		step_d = step_q;
		mix_d  = mix_q;
		cut_d  = cut_q;
		priority if (is_restart || negative) begin
			step_d = is_restart ? dt_initial_q : shrink_prod[DT_W+MIX_W-1:MIX_W];
			mix_d  = mix_start_q;
			cut_d  = $signed({1'b0, min_steps_q});
		end else if (cut_q[CUT_W-1]) begin
			step_d = grown_cap;
			mix_d  = decay_prod[2*MIX_W-1:MIX_W];
		end else begin
			cut_d  = cut_q - CUT_W'(1);
		end
	end

	// One bit of each serial operation.
	assign mul_sum  = {1'b0, acc_q[PROD_W-1:NORM_W]} + (v_q[0] ? {1'b0, m2_q} : '0);
	assign acc_mul  = {mul_sum, acc_q[NORM_W-1:1]};
	assign saturate = (NORM_W'(acc_mul[PROD_W-1:QUO_W]) >= f_q);
	assign div_t    = {rem_q, acc_q[QUO_W-1]};
	assign div_ge   = (div_t >= {1'b0, f_q});
	assign sq_t     = {srem_q, acc_q[QUO_W-1:QUO_W-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_t >= sq_trial);

	// Configuration and controller state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_steps_q     <= MIN_STEPS_RST;
			grow_factor_q   <= GROW_FACTOR_RST;
			shrink_factor_q <= SHRINK_FACTOR_RST;
			mix_start_q     <= MIX_START_RST;
			mix_decay_q     <= MIX_DECAY_RST;
			dt_ceiling_q    <= DT_CEILING_RST;
			dt_initial_q    <= DT_INITIAL_RST;
			step_q          <= DT_INITIAL_RST;
			mix_q           <= MIX_START_RST;
			cut_q           <= $signed({1'b0, MIN_STEPS_RST});
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_STEPS:     min_steps_q     <= cfg_data[STEPS_W-1:0];
					REG_GROW_FACTOR:   grow_factor_q   <= cfg_data[MIX_W-1:0];
					REG_SHRINK_FACTOR: shrink_factor_q <= cfg_data[MIX_W-1:0];
					REG_MIX_START:     mix_start_q     <= cfg_data[MIX_W-1:0];
					REG_MIX_DECAY:     mix_decay_q     <= cfg_data[MIX_W-1:0];
					REG_DT_CEILING:    dt_ceiling_q    <= cfg_data[DT_W-1:0];
					REG_DT_INITIAL:    dt_initial_q    <= cfg_data[DT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				step_q <= step_d;
				mix_q  <= mix_d;
				cut_q  <= cut_d;
			end
		end
	end

	// Serial datapath; the coefficient uses the mixing factor from before the request.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					m2_q     <= mix_q * mix_q;
					v_q      <= req.vel_norm_sq;
					f_q      <= req.force_norm_sq;
					acc_q    <= '0;
					fc_q     <= '0;
					keep_w_q <= KEEP_ONE - KEEP_W'(is_restart ? mix_start_q : mix_q);
					zv_w_q   <= !is_restart && negative;
					dt_w_q   <= step_d;
					chg_w_q  <= (step_d != step_q);
				end
			end
			ST_MUL: begin
				acc_q <= acc_mul;
				v_q   <= v_q >> 1;
				if (cnt_q == '0) begin
					rem_q <= NORM_W'(acc_mul[PROD_W-1:QUO_W]);
					if (saturate) begin
						fc_q <= '1;
					end
				end
			end
			ST_DIV: begin
				rem_q              <= div_ge ? NORM_W'(div_t - {1'b0, f_q}) : div_t[NORM_W-1:0];
				acc_q[QUO_W-1:0]   <= {acc_q[QUO_W-2:0], div_ge};
				srem_q             <= '0;
				root_q             <= '0;
			end
			ST_SQRT: begin
				srem_q           <= sq_ge ? SREM_W'(sq_t - sq_trial) : sq_t[SREM_W-1:0];
				root_q           <= {root_q[ROOT_W-2:0], sq_ge};
				acc_q[QUO_W-1:0] <= {acc_q[QUO_W-3:0], 2'b00};
				if (cnt_q == '0) begin
					fc_q <= {root_q[ROOT_W-2:0], sq_ge};
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
			keep_q      <= '0;
			force_q     <= '0;
			zv_q        <= 1'b0;
			new_dt_q    <= '0;
			chg_q       <= 1'b0;
		end else begin
			if (out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (is_restart || zero_force) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_MUL;
							cnt_q   <= CNT_W'(NORM_W - 1);
						end
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						if (saturate) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_DIV;
							cnt_q   <= CNT_W'(QUO_W - 1);
						end
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DIV: begin
					if (cnt_q == '0) begin
						state_q <= ST_SQRT;
						cnt_q   <= CNT_W'(ROOT_W - 1);
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						keep_q      <= keep_w_q;
						force_q     <= fc_q;
						zv_q        <= zv_w_q;
						new_dt_q    <= dt_w_q;
						chg_q       <= chg_w_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.keep_coeff    = keep_q;
	assign rsp.force_coeff   = force_q;
	assign rsp.zero_velocity = zv_q;
	assign rsp.new_dt        = new_dt_q;
	assign rsp.dt_changed    = chg_q;

endmodule

@@ verif/fsc_step_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsc_step_checker: predictor and scoreboard for the FIRE step controller
// Mirrors the configuration registers and the controller state, works out
// the coefficients and time step for every accepted request, and compares
// every accepted response with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module fsc_step_checker #(
	parameter logic RESTART_KIND = 1'b0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [fsc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [fsc_pkg::CFG_DATA_W-1:0]  cfg_data,
	fsc_req_if                              req,
	fsc_rsp_if                              rsp,
	output int unsigned                     fail_count,
	output int unsigned                     pending_count
);
	import fsc_pkg::*;

	typedef struct packed {
		logic [KEEP_W-1:0]  keep_coeff;
		logic [COEFF_W-1:0] force_coeff;
		logic               zero_velocity;
		logic [DT_W-1:0]    new_dt;
		logic               dt_changed;
	} step_coeffs_t;

	step_coeffs_t coeffs_due[$];

	logic [STEPS_W-1:0] min_steps;
	logic [MIX_W-1:0]   grow_factor;
	logic [MIX_W-1:0]   shrink_factor;
	logic [MIX_W-1:0]   mix_start;
	logic [MIX_W-1:0]   mix_decay;
	logic [DT_W-1:0]    dt_ceiling;
	logic [DT_W-1:0]    dt_initial;

	logic [DT_W-1:0]    step_size;
	logic [MIX_W-1:0]   mix_factor;
	int                 cut_count;
	int unsigned        errs;

	// floor(mix * sqrt(v / f)) in Q16.16, taken as the integer square root
	// of floor(mix^2 * v / f); a quotient of 2^64 or more saturates.
	function automatic logic [COEFF_W-1:0] force_weight(input logic [MIX_W-1:0] mix,
			input logic [NORM_W-1:0] vn, input logic [NORM_W-1:0] fn);
		logic [127:0] quot;
		logic [31:0]  root;
		logic [31:0]  trial;
		if (fn == '0)
			return '0;
		quot = (128'(mix) * 128'(mix) * 128'(vn)) / 128'(fn);
		if (quot[127:64] != '0)
			return '1;
		root = '0;
		for (int b = 31; b >= 0; b--) begin
			trial = root | (32'd1 << b);
			if (64'(trial) * 64'(trial) <= quot[63:0])
				root = trial;
		end
		return root;
	endfunction

	task automatic predict_step(input logic kind, input logic [POWER_W-1:0] power,
			input logic [NORM_W-1:0] vn, input logic [NORM_W-1:0] fn);
		step_coeffs_t     due;
		logic [DT_W-1:0]  prev_dt;
		logic [63:0]      grown;
		prev_dt = step_size;
		due = '0;
		if (kind == RESTART_KIND) begin
			step_size = dt_initial;
			mix_factor = mix_start;
			cut_count = int'(min_steps);
			due.keep_coeff = KEEP_ONE - KEEP_W'(mix_factor);
		end else begin
			// Both coefficients use the mixing factor from before this request.
			due.keep_coeff = KEEP_ONE - KEEP_W'(mix_factor);
			due.force_coeff = force_weight(mix_factor, vn, fn);
			if (power[POWER_W-1]) begin
				due.zero_velocity = 1'b1;
				cut_count = int'(min_steps);
				step_size = DT_W'((64'(step_size) * 64'(shrink_factor)) >> 16);
				mix_factor = mix_start;
			end else if (cut_count < 0) begin
				grown = (64'(step_size) * 64'(grow_factor)) >> 14;
				if (grown > 64'(dt_ceiling))
					grown = 64'(dt_ceiling);
				step_size = grown[DT_W-1:0];
				mix_factor = MIX_W'((32'(mix_factor) * 32'(mix_decay)) >> 16);
			end else begin
				cut_count--;
			end
		end
		due.new_dt = step_size;
		due.dt_changed = (step_size != prev_dt);
		coeffs_due.push_back(due);
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			errs++;
			if (errs <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name,
					want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		step_coeffs_t due;
		if (!arst_n) begin
			min_steps = MIN_STEPS_RST;
			grow_factor = GROW_FACTOR_RST;
			shrink_factor = SHRINK_FACTOR_RST;
			mix_start = MIX_START_RST;
			mix_decay = MIX_DECAY_RST;
			dt_ceiling = DT_CEILING_RST;
			dt_initial = DT_INITIAL_RST;
			step_size = DT_INITIAL_RST;
			mix_factor = MIX_START_RST;
			cut_count = int'(MIN_STEPS_RST);
			coeffs_due.delete();
			errs = 0;
			fail_count <= 0;
			pending_count <= 0;
		end else begin
			// Responses are checked before this edge's request is predicted, so
			// a stray response cannot be matched against its own request.
			if (rsp.valid && rsp.ready) begin
				if (coeffs_due.size() == 0) begin
					errs++;
					if (errs <= 10)
						$display("%0t: response with no request outstanding", $realtime);
				end else begin
					due = coeffs_due.pop_front();
					check_field("keep_coeff", 64'(due.keep_coeff), 64'(rsp.keep_coeff));
					check_field("force_coeff", 64'(due.force_coeff), 64'(rsp.force_coeff));
					check_field("zero_velocity", 64'(due.zero_velocity),
						64'(rsp.zero_velocity));
					check_field("new_dt", 64'(due.new_dt), 64'(rsp.new_dt));
					check_field("dt_changed", 64'(due.dt_changed), 64'(rsp.dt_changed));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_MIN_STEPS:     min_steps = cfg_data[STEPS_W-1:0];
					REG_GROW_FACTOR:   grow_factor = cfg_data[MIX_W-1:0];
					REG_SHRINK_FACTOR: shrink_factor = cfg_data[MIX_W-1:0];
					REG_MIX_START:     mix_start = cfg_data[MIX_W-1:0];
					REG_MIX_DECAY:     mix_decay = cfg_data[MIX_W-1:0];
					REG_DT_CEILING:    dt_ceiling = cfg_data[DT_W-1:0];
					REG_DT_INITIAL:    dt_initial = cfg_data[DT_W-1:0];
					default: begin
					end
				endcase
			end
			if (req.valid && req.ready)
				predict_step(req.kind, req.power, req.vel_norm_sq, req.force_norm_sq);
			fail_count <= errs;
			pending_count <= coeffs_due.size();
		end
	end

endmodule

@@ verif/tb_fire_step_controller_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fire_step_controller_core: stimulus and verdict for the step controller
// Drives directed and random step requests across several register settings,
// with random sender gaps and receiver stalls; checking is done by the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_fire_step_controller_core;
	import fsc_pkg::*;

	localparam logic KIND_RESTART = 1'b0;
	localparam logic KIND_STEP    = 1'b1;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 3'd7;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned TAIL_CYCLES = 300;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           fail_count;
	int unsigned           pending_count;
	int unsigned           cycle_count = 0;
	int unsigned           stall_left = 0;
	int unsigned           requests_sent = 0;
	int unsigned           restarts_sent = 0;
	int unsigned           settings_run = 0;
	logic                  idling_on;
	logic [STEPS_W-1:0]    cur_min_steps;

	fsc_req_if req_ch();
	fsc_rsp_if rsp_ch();

	fire_step_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	fsc_step_checker #(
		.RESTART_KIND (KIND_RESTART)
	) step_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Receiver stalls come in bursts of random length, only while idling is on.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if (idling_on && $urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 3);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	function automatic logic [NORM_W-1:0] rand_norm();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0)
			return '1;
		return NORM_W'(raw & ((64'd1 << $urandom_range(0, NORM_W)) - 64'd1));
	endfunction

	// Magnitude of random width below the sign bit, so that zero, small and
	// full-scale powers all turn up on either side.
	function automatic logic [POWER_W-1:0] rand_power(input logic negative);
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		if ($urandom_range(0, 15) == 0)
			raw = '1;
		else
			raw = raw & ((64'd1 << $urandom_range(0, POWER_W - 1)) - 64'd1);
		return {negative, raw[POWER_W-2:0]};
	endfunction

	function automatic logic [POWER_W-1:0] rand_word48();
		logic [63:0] raw;
		raw = {$urandom, $urandom};
		return raw[POWER_W-1:0];
	endfunction

	task automatic send_item(input logic kind, input logic [POWER_W-1:0] power,
			input logic [NORM_W-1:0] vn, input logic [NORM_W-1:0] fn);
		int unsigned gap;
		gap = (idling_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.power <= power;
		req_ch.vel_norm_sq <= vn;
		req_ch.force_norm_sq <= fn;
		do @(posedge clk); while (!req_ch.ready);
		requests_sent++;
		if (kind == KIND_RESTART)
			restarts_sent++;
	endtask

	// The first edge only lets the checker book the last request.
	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// Narrow registers get random junk above their width, which must be dropped.
	task automatic program_registers(input logic [STEPS_W-1:0] ms, input logic [MIX_W-1:0] gf,
			input logic [MIX_W-1:0] sf, input logic [MIX_W-1:0] mst,
			input logic [MIX_W-1:0] md, input logic [DT_W-1:0] ceil,
			input logic [DT_W-1:0] init);
		write_reg(REG_MIN_STEPS, {24'($urandom_range(0, 16777215)), ms});
		write_reg(REG_GROW_FACTOR, {16'($urandom), gf});
		write_reg(CFG_IDX_UNUSED, $urandom);
		write_reg(REG_SHRINK_FACTOR, {16'($urandom), sf});
		write_reg(REG_MIX_START, {16'($urandom), mst});
		write_reg(REG_MIX_DECAY, {16'($urandom), md});
		write_reg(REG_DT_CEILING, ceil);
		write_reg(REG_DT_INITIAL, init);
		cfg_we <= 1'b0;
		cur_min_steps = ms;
		settings_run++;
	endtask

	task automatic program_random(input int unsigned ms_max);
		program_registers(STEPS_W'($urandom_range(0, ms_max)), MIX_W'($urandom),
			MIX_W'($urandom), MIX_W'($urandom), MIX_W'($urandom), $urandom,
			$urandom >> $urandom_range(0, 24));
	endtask

	// Mostly runs of non-negative power, often long enough to reach growth, each
	// ended by a cut; a few restarts and stray signs break the pattern.
	task automatic run_random(input int unsigned n_items);
		int unsigned sent;
		int unsigned run_len;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(0, 39) == 0) begin
				send_item(KIND_RESTART, rand_word48(), rand_norm(), rand_norm());
				sent++;
			end else begin
				run_len = $urandom_range(0, 2 * int'(cur_min_steps) + 4);
				for (int i = 0; i < run_len && sent < n_items; i++) begin
					send_item(KIND_STEP, rand_power($urandom_range(0, 19) == 0), rand_norm(),
						rand_norm());
					sent++;
				end
				if (sent < n_items) begin
					send_item(KIND_STEP, rand_power(1'b1), rand_norm(), rand_norm());
					sent++;
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_RESTART;
		req_ch.power = '0;
		req_ch.vel_norm_sq = '0;
		req_ch.force_norm_sq = '0;
		rsp_ch.ready = 1'b0;
		idling_on = 1'b0;
		cur_min_steps = MIN_STEPS_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		idling_on <= 1'b1;

		// Directed part on the reset register values.
		send_item(KIND_RESTART, rand_word48(), '1, 48'd1);
		send_item(KIND_STEP, '1, '1, 48'd1);
		send_item(KIND_STEP, {1'b1, 47'd0}, '0, '0);
		send_item(KIND_STEP, '0, '0, '1);
		send_item(KIND_STEP, {1'b0, {(POWER_W - 1){1'b1}}}, '1, '1);
		send_item(KIND_STEP, 48'd1, 48'd1, '1);
		send_item(KIND_STEP, 48'd5, '1, 48'd1);
		for (int i = 0; i < 13; i++)
			send_item(KIND_STEP, rand_power(1'b0), rand_norm(), rand_norm() | 48'd1);
		send_item(KIND_STEP, rand_power(1'b1), rand_norm(), rand_norm());
		send_item(KIND_RESTART, '0, '0, '0);
		wait_drain();

		// All registers at zero, first without reloading the state.
		program_registers('0, '0, '0, '0, '0, '0, '0);
		run_random(40);
		send_item(KIND_RESTART, rand_word48(), rand_norm(), rand_norm());
		run_random(40);
		wait_drain();

		// All registers at their largest values.
		program_registers('1, '1, '1, '1, '1, '1, '1);
		send_item(KIND_RESTART, rand_word48(), rand_norm(), rand_norm());
		run_random(300);
		wait_drain();

		// Largest factors with no hold-off after a cut.
		program_registers('0, '1, '1, '1, '1, '1, 32'd1);
		send_item(KIND_RESTART, rand_word48(), rand_norm(), rand_norm());
		run_random(80);

		for (int p = 0; p < 5; p++) begin
			wait_drain();
			if (p == 4)
				idling_on <= 1'b0;
			program_random(5);
			if ($urandom_range(0, 1) == 0)
				send_item(KIND_RESTART, rand_word48(), rand_norm(), rand_norm());
			run_random(110);
		end

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Covered %0d requests, %0d of them restarts, over %0d register settings.",
			requests_sent, restarts_sent, settings_run);
		$display("Settings spanned all-zero and all-ones registers; the last ran without stalls.");
		if (fail_count == 0 && pending_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
